// ===== rtl/core/dsc_pkg.sv =====
// Shared types and constants of the dictionary segmentation counter.
// No dependencies.
package dsc_pkg;
  localparam int MaxPatterns   = 64;
  localparam int MaxPatternLen = 8;
  localparam int SymbolBits    = 8;
  localparam int IdxW          = $clog2(MaxPatterns);
  localparam int CntW          = $clog2(MaxPatterns + 1);
  localparam int LenW          = 4;
  localparam int WayW          = 63;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAdd   = 2'd1;
  localparam logic [1:0] OpFeed  = 2'd2;
  localparam logic [1:0] OpNone  = 2'd3;

  localparam logic [WayW-1:0] CountMax = {WayW{1'b1}};

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] text;
    logic [3:0]  len;
    logic [7:0]  symbol;
    logic        last;
  } cmd_t;

  // Keep only the valid symbols of a pattern, each reduced to SymbolBits.
  function automatic logic [63:0] pack_valid(input logic [63:0] text,
                                             input logic [3:0] len);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < 32'(len)) begin
        r[8*k +: SymbolBits] = text[8*k +: SymbolBits];
      end
    end
    return r;
  endfunction
endpackage

// ===== rtl/core/dsc_in_if.sv =====
// Input channel of the dictionary segmentation counter.
// Depends on nothing.
interface dsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] pattern_text;
  logic [3:0]  pattern_length;
  logic [7:0]  symbol;
  logic        last_symbol;
  modport source(output valid, opcode, pattern_text, pattern_length, symbol, last_symbol,
                 input ready);
  modport sink(input valid, opcode, pattern_text, pattern_length, symbol, last_symbol,
               output ready);
endinterface

// ===== rtl/core/dsc_out_if.sv =====
// Result channel of the dictionary segmentation counter.
// Depends on nothing.
interface dsc_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] way_count;
  logic        can_be_made;
  logic        saturated;
  modport source(output valid, way_count, can_be_made, saturated, input ready);
  modport sink(input valid, way_count, can_be_made, saturated, output ready);
endinterface

// ===== rtl/core/dictionary_segmentation_counter.sv =====
// Top level of the dictionary segmentation counter.
// Depends on dsc_pkg, dsc_in_if, dsc_out_if, dsc_front and dsc_back.
//
// Counts the ways a symbol string splits into stored patterns. A clear is
// handled in the back end without a scan; an add or a design symbol scans the
// dictionary one entry per cycle through a single memory read port. A
// two-entry transaction queue lets the input side run ahead of the scan, and
// a result register holds the finished count until it is taken.
module dictionary_segmentation_counter import dsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsc_in_if.sink    in_i,
  dsc_out_if.source out_o
);
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  dsc_front u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  dsc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_pop_o(cmd_pop), .out_o
  );
endmodule

// ===== rtl/core/dsc_front.sv =====
// Front end: accepts transactions, drops opcode 3 and bad-length adds,
// and queues the rest in a two-entry FIFO. Depends on dsc_pkg.
module dsc_front import dsc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  dsc_in_if.sink in_i,
  output logic   cmd_valid_o,
  output cmd_t   cmd_o,
  input  logic   cmd_pop_i
);
  cmd_t       fifo_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       push, keep;

  assign in_i.ready = (cnt_q != 2'd2);
  assign keep = (in_i.opcode == OpClear) || (in_i.opcode == OpFeed) ||
                ((in_i.opcode == OpAdd) && (in_i.pattern_length != '0) &&
                 (32'(in_i.pattern_length) <= MaxPatternLen));
  assign push = in_i.valid && in_i.ready && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{in_i.opcode, in_i.pattern_text, in_i.pattern_length,
                        in_i.symbol, in_i.last_symbol};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("push into full queue");
endmodule

// ===== rtl/core/dsc_back.sv =====
// Back end: holds the dictionary and the count window, and scans the
// dictionary one entry per cycle for each add or feed command. Depends on dsc_pkg.
module dsc_back import dsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  cmd_t     cmd_i,
  output logic     cmd_pop_o,
  dsc_out_if.source out_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [63:0]     pat_mem [MaxPatterns];
  logic [LenW-1:0] len_mem [MaxPatterns];

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, idx_q;
  logic [63:0]     rd_text_q;
  logic [LenW-1:0] rd_len_q;
  logic            rd_vld_q;
  logic [7:0]      sym_q [MaxPatternLen];
  logic [WayW-1:0] win_q [MaxPatternLen];
  logic [WayW-1:0] sum_q;
  logic            sat_q, dup_q;
  logic [63:0]     packed_cmd;
  logic            match, equal;
  logic [2:0]      sym_idx;
  logic [WayW:0]   add_w;
  logic [WayW-1:0] out_cnt_q;
  logic            out_sat_q, out_vld_q;
  logic            out_load;

  assign packed_cmd = pack_valid(cmd_i.text, cmd_i.len);

  always_comb begin
    match   = 1'b1;
    sym_idx = '0;
    for (int k = 0; k < MaxPatternLen; k++) begin
      sym_idx = 3'(rd_len_q - 4'd1 - 4'(k));
      if (k < 32'(rd_len_q) &&
          rd_text_q[8*k +: SymbolBits] != sym_q[sym_idx][SymbolBits-1:0]) begin
        match = 1'b0;
      end
    end
  end
  assign equal = (rd_len_q == cmd_i.len) && (rd_text_q == packed_cmd);
  assign add_w = {1'b0, sum_q} + {1'b0, win_q[3'(rd_len_q - 4'd1)]};

  assign out_load = (state_q == StDone) && cmd_pop_o && (cmd_i.opcode == OpFeed) &&
                    cmd_i.last;

  assign out_o.valid       = out_vld_q;
  assign out_o.way_count   = out_cnt_q;
  assign out_o.can_be_made = (out_cnt_q != '0);
  assign out_o.saturated   = out_sat_q;

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      StIdle: if (cmd_valid_i) begin
        if (cmd_i.opcode == OpClear) cmd_pop_o = 1'b1;
        else state_d = StScan;
      end
      StScan: if (idx_q == count_q && !rd_vld_q) state_d = StDone;
      StDone: begin
        cmd_pop_o = 1'b1;
        state_d = (cmd_i.opcode == OpFeed && cmd_i.last) ? StOut : StIdle;
        if (state_d == StOut && !(out_vld_q && !out_o.ready)) state_d = StIdle;
        if (out_vld_q && !out_o.ready && cmd_i.opcode == OpFeed && cmd_i.last) begin
          cmd_pop_o = 1'b0;
          state_d = StDone;
        end
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Dictionary reads, registered.
  always_ff @(posedge clk_i) begin
    rd_text_q <= pat_mem[idx_q[IdxW-1:0]];
    rd_len_q  <= len_mem[idx_q[IdxW-1:0]];
    if (state_q == StDone && cmd_pop_o && cmd_i.opcode == OpAdd && !dup_q &&
        count_q != CntW'(MaxPatterns)) begin
      pat_mem[count_q[IdxW-1:0]] <= packed_cmd;
      len_mem[count_q[IdxW-1:0]] <= cmd_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; count_q <= '0; idx_q <= '0; rd_vld_q <= 1'b0;
      sum_q <= '0; sat_q <= 1'b0; dup_q <= 1'b0;
      out_vld_q <= 1'b0; out_cnt_q <= '0; out_sat_q <= 1'b0;
      for (int k = 0; k < MaxPatternLen; k++) begin
        sym_q[k] <= '0;
        win_q[k] <= (k == 0) ? WayW'(1) : '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) out_vld_q <= 1'b1;
      else if (out_vld_q && out_o.ready) out_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          idx_q <= '0; rd_vld_q <= 1'b0; sum_q <= '0; dup_q <= 1'b0;
          if (cmd_valid_i && cmd_i.opcode == OpClear) count_q <= '0;
          if (cmd_valid_i && cmd_i.opcode == OpFeed) begin
            for (int k = MaxPatternLen - 1; k > 0; k--) sym_q[k] <= sym_q[k-1];
            sym_q[0] <= cmd_i.symbol;
          end
        end
        StScan: begin
          rd_vld_q <= (idx_q != count_q);
          if (idx_q != count_q) idx_q <= idx_q + 1'b1;
          if (rd_vld_q) begin
            if (cmd_i.opcode == OpAdd) begin
              if (equal) dup_q <= 1'b1;
            end else if (match) begin
              if (add_w >= {1'b0, CountMax}) begin
                sum_q <= CountMax; sat_q <= 1'b1;
              end else begin
                sum_q <= add_w[WayW-1:0];
              end
            end
          end
        end
        StDone: if (cmd_pop_o) begin
          if (cmd_i.opcode == OpAdd) begin
            if (!dup_q && count_q != CntW'(MaxPatterns)) count_q <= count_q + 1'b1;
          end else if (cmd_i.last) begin
            out_cnt_q <= sum_q; out_sat_q <= sat_q;
            sat_q <= 1'b0;
            for (int k = 0; k < MaxPatternLen; k++) begin
              sym_q[k] <= '0;
              win_q[k] <= (k == 0) ? WayW'(1) : '0;
            end
          end else begin
            for (int k = MaxPatternLen - 1; k > 0; k--) win_q[k] <= win_q[k-1];
            win_q[0] <= sum_q;
          end
        end
        StOut: ;
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPatterns)) else $error("pattern count overflow");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= count_q) else $error("scan index past pattern count");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> out_vld_q) else $error("result dropped");
endmodule
